/* rtl/core/idct_8point_column_pass_defines.svh */
// Assertion macros for the column IDCT pipeline.
`ifndef IDCT_8POINT_COLUMN_PASS_DEFINES_SVH
`define IDCT_8POINT_COLUMN_PASS_DEFINES_SVH

`ifndef SYNTHESIS
// Checked after reset is released.
`define IDCT8_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("idct8 check failed");
// Checked during reset as well.
`define IDCT8_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("idct8 check failed");
`else
`define IDCT8_ASSERT(lbl, clk, rst_n, prop)
`define IDCT8_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

/* rtl/core/idct8_pkg.sv */
`timescale 1ns / 1ps

package idct8_pkg;

  localparam int NumStages = 4;

  typedef logic signed [31:0] word_t;
  // Eight 16-bit lanes, lane 0 in the lowest bits.
  typedef logic [7:0][15:0] col_t;

  // 12-bit cosine weights, 2048*sqrt(2)*cos(k*pi/16).
  localparam word_t K1 = 32'sd2841;
  localparam word_t K2 = 32'sd2676;
  localparam word_t K3 = 32'sd2408;
  localparam word_t K5 = 32'sd1609;
  localparam word_t K6 = 32'sd1108;
  localparam word_t K7 = 32'sd565;
  localparam word_t KR = 32'sd181;

  localparam word_t K1mK7 = K1 - K7;
  localparam word_t K1pK7 = K1 + K7;
  localparam word_t K3mK5 = K3 - K5;
  localparam word_t K3pK5 = K3 + K5;
  localparam word_t K2pK6 = K2 + K6;
  localparam word_t K2mK6 = K2 - K6;

  localparam word_t DcBias = 32'sd8192;
  localparam word_t RndMul = 32'sd4;
  localparam word_t RndRot = 32'sd128;

  // Products of the first stage.
  typedef struct packed {
    word_t t_a;
    word_t p4;
    word_t p5;
    word_t t_b;
    word_t p6;
    word_t p7;
    word_t t_e;
    word_t p2;
    word_t p3;
    word_t e_sum;
    word_t e_dif;
  } s1_t;

  // Butterfly results, named as in the Chen-Wang flow graph.
  typedef struct packed {
    word_t a0;
    word_t a1;
    word_t a2;
    word_t a3;
    word_t a4;
    word_t a5;
    word_t a6;
    word_t a7;
    word_t t;
  } bfly_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctl_t;

endpackage

/* rtl/core/idct8_ctl.sv */
`timescale 1ns / 1ps
`include "idct_8point_column_pass_defines.svh"

module idct8_ctl
  import idct8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pipe_ctl_t  ctl_o
);

  logic [NumStages-1:0] valid_q, valid_d, ready;

  // A stage may load when it is empty or its successor takes its content.
  always_comb begin
    ready[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d = valid_q;
    if (ready[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ready[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign ctl_o.load  = ready;

  `IDCT8_ASSERT(a_empty_out_ready, clk_i, rst_ni, !valid_q[NumStages-1] |-> in_ready_o)
  `IDCT8_ASSERT(a_drain_ready, clk_i, rst_ni, out_ready_i |-> in_ready_o)
  `IDCT8_ASSERT(a_accept_fills, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> valid_q[0])
  `IDCT8_ASSERT(a_stall_holds, clk_i, rst_ni, (valid_q[0] && !ready[0]) |=> valid_q[0])
  `IDCT8_ASSERT_ANY(a_reset_empty, clk_i, !rst_ni |=> (valid_q == '0))

endmodule

/* rtl/core/idct8_mul.sv */
`timescale 1ns / 1ps

module idct8_mul
  import idct8_pkg::*;
(
  input  logic  clk_i,
  input  logic  load_i,
  input  col_t  coef_i,
  output s1_t   s1_o
);

  word_t c [8];
  s1_t   s1_d, s1_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      c[k] = {{16{coef_i[k][15]}}, coef_i[k]};
    end
    // odd part
    s1_d.t_a = K7 * (c[1] + c[7]) + RndMul;
    s1_d.p4  = K1mK7 * c[1];
    s1_d.p5  = K1pK7 * c[7];
    s1_d.t_b = K3 * (c[5] + c[3]) + RndMul;
    s1_d.p6  = K3mK5 * c[5];
    s1_d.p7  = K3pK5 * c[3];
    // even part, DC and row 4 scaled by 256
    s1_d.t_e   = K6 * (c[2] + c[6]) + RndMul;
    s1_d.p2    = K2pK6 * c[6];
    s1_d.p3    = K2mK6 * c[2];
    s1_d.e_sum = (c[0] <<< 8) + DcBias + (c[4] <<< 8);
    s1_d.e_dif = (c[0] <<< 8) + DcBias - (c[4] <<< 8);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

/* rtl/core/idct8_bfly.sv */
`timescale 1ns / 1ps

module idct8_bfly
  import idct8_pkg::*;
(
  input  logic   clk_i,
  input  logic   load_i,
  input  s1_t    s1_i,
  output bfly_t  bf_o
);

  word_t o4, o5, o6, o7, e2, e3;
  bfly_t bf_d, bf_q;

  always_comb begin
    o4 = (s1_i.t_a + s1_i.p4) >>> 3;
    o5 = (s1_i.t_a - s1_i.p5) >>> 3;
    o6 = (s1_i.t_b - s1_i.p6) >>> 3;
    o7 = (s1_i.t_b - s1_i.p7) >>> 3;
    e2 = (s1_i.t_e - s1_i.p2) >>> 3;
    e3 = (s1_i.t_e + s1_i.p3) >>> 3;

    bf_d.a1 = o4 + o6;
    bf_d.a4 = o4 - o6;
    bf_d.a6 = o5 + o7;
    bf_d.a5 = o5 - o7;
    bf_d.a7 = s1_i.e_sum + e3;
    bf_d.t  = s1_i.e_sum - e3;
    bf_d.a3 = s1_i.e_dif + e2;
    bf_d.a0 = s1_i.e_dif - e2;
    bf_d.a2 = '0; // filled by the rotation stage
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bf_q <= bf_d;
    end
  end

  assign bf_o = bf_q;

endmodule

/* rtl/core/idct8_fin.sv */
`timescale 1ns / 1ps

module idct8_fin
  import idct8_pkg::*;
(
  input  logic   clk_i,
  input  logic   rot_load_i,
  input  logic   out_load_i,
  input  bfly_t  bf_i,
  output col_t   pix_o
);

  bfly_t rot_d, rot_q;
  word_t sum [8];
  col_t  pix_d, pix_q;

  // Rotation by 1/sqrt(2) on the odd pair.
  always_comb begin
    rot_d    = bf_i;
    rot_d.a2 = (KR * (bf_i.a4 + bf_i.a5) + RndRot) >>> 8;
    rot_d.a4 = (KR * (bf_i.a4 - bf_i.a5) + RndRot) >>> 8;
  end

  always_ff @(posedge clk_i) begin
    if (rot_load_i) begin
      rot_q <= rot_d;
    end
  end

  // Final butterfly, shift by 14, keep low 16 bits.
  always_comb begin
    sum[0] = (rot_q.a7 + rot_q.a1) >>> 14;
    sum[7] = (rot_q.a7 - rot_q.a1) >>> 14;
    sum[1] = (rot_q.a3 + rot_q.a2) >>> 14;
    sum[6] = (rot_q.a3 - rot_q.a2) >>> 14;
    sum[2] = (rot_q.a0 + rot_q.a4) >>> 14;
    sum[5] = (rot_q.a0 - rot_q.a4) >>> 14;
    sum[3] = (rot_q.t + rot_q.a6) >>> 14;
    sum[4] = (rot_q.t - rot_q.a6) >>> 14;
    for (int k = 0; k < 8; k++) begin
      pix_d[k] = sum[k][15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

/* rtl/core/idct_8point_column_pass.sv */
`timescale 1ns / 1ps
// Column pass of an 8-point Chen-Wang fixed-point inverse DCT.
// Slave stream (s_axis_*): one transaction carries one column of eight
//   signed 16-bit coefficients, coef_0 in tdata[15:0] up to coef_7 in
//   tdata[127:112].
// Master stream (m_axis_*): one transaction per column carries the eight
//   spatial outputs pix_0..pix_7, packed the same way; each is the low 16
//   bits of the shifted result, never clipped.
// Pipeline: four register stages between input transaction and output
//   tvalid (products, butterflies, rotation, final sum/shift).
// Throughput: one column per cycle; every stage loads each cycle when the
//   pipe flows.
// Stalls: each stage holds while its successor is full and blocked, so a
//   low m_axis_tready backs up stage by stage; empty stages still fill, and
//   s_axis_tready only drops once all four stages hold data.
// Reset: rst_ni (async, active low) clears the stage valid bits only;
//   the block is stateless between columns.
module idct_8point_column_pass
  import idct8_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // coef_0 .. coef_7, 16 bits each
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata    // pix_0 .. pix_7, 16 bits each
);

  pipe_ctl_t ctl;
  s1_t       s1;
  bfly_t     bf;
  col_t      pix;

  // Handshake and per-stage load enables.
  idct8_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  // Stage 1: constant multiplies of the odd and even inputs.
  idct8_mul u_mul (
    .clk_i  (clk_i),
    .load_i (ctl.load[0]),
    .coef_i (col_t'(s_axis_tdata)),
    .s1_o   (s1)
  );

  // Stage 2: rounding shifts and the butterflies ahead of the rotation.
  idct8_bfly u_bfly (
    .clk_i  (clk_i),
    .load_i (ctl.load[1]),
    .s1_i   (s1),
    .bf_o   (bf)
  );

  // Stages 3 and 4: odd rotation, then output butterfly and scaling.
  idct8_fin u_fin (
    .clk_i      (clk_i),
    .rot_load_i (ctl.load[2]),
    .out_load_i (ctl.load[3]),
    .bf_i       (bf),
    .pix_o      (pix)
  );

  assign m_axis_tdata = pix;

endmodule

/* verif/idct_8point_column_pass_tb.sv */
`timescale 1ns / 1ps

module idct_8point_column_pass_tb;
  import idct8_pkg::*;

  // Cosine weights of the column butterflies, kept apart from the RTL copy.
  localparam int W1 = 2841;
  localparam int W2 = 2676;
  localparam int W3 = 2408;
  localparam int W5 = 1609;
  localparam int W6 = 1108;
  localparam int W7 = 565;
  localparam int WR = 181;
  localparam int DC_OFFSET = 8192;

  localparam int RANDOM_COLUMNS = 1000;
  localparam int DRAIN_CYCLES = 16;       // pipe is 4 deep, plenty of margin
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;        // coef_0 .. coef_7, 16 bits each
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;             // pix_0 .. pix_7, 16 bits each

  col_t coef_pending[$];   // columns waiting to be driven
  col_t pix_expected[$];   // predicted outputs of accepted columns, oldest first

  int unsigned src_idle_pct = 10;
  int unsigned sink_stall_pct = 47;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  idct_8point_column_pass DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Fixed-point column IDCT. int arithmetic wraps mod 2^32 and >>> on int
  // is arithmetic, which matches the block's 32-bit datapath.
  function automatic col_t idct_column(input col_t coef);
    int x0, x1, x2, x3, x4, x5, x6, x7, t;
    int r [8];
    col_t pix;
    x0 = int'($signed(coef[0]));
    x1 = int'($signed(coef[4]));
    x2 = int'($signed(coef[6]));
    x3 = int'($signed(coef[2]));
    x4 = int'($signed(coef[1]));
    x5 = int'($signed(coef[7]));
    x6 = int'($signed(coef[5]));
    x7 = int'($signed(coef[3]));
    x1 = x1 << 8;
    x0 = (x0 << 8) + DC_OFFSET;

    // odd half
    t  = W7 * (x4 + x5) + 4;
    x4 = (t + (W1 - W7) * x4) >>> 3;
    x5 = (t - (W1 + W7) * x5) >>> 3;
    t  = W3 * (x6 + x7) + 4;
    x6 = (t - (W3 - W5) * x6) >>> 3;
    x7 = (t - (W3 + W5) * x7) >>> 3;

    // even half
    t  = x0 + x1;
    x0 = x0 - x1;
    x1 = W6 * (x3 + x2) + 4;
    x2 = (x1 - (W2 + W6) * x2) >>> 3;
    x3 = (x1 + (W2 - W6) * x3) >>> 3;

    // butterflies
    x1 = x4 + x6;
    x4 = x4 - x6;
    x6 = x5 + x7;
    x5 = x5 - x7;
    x7 = t + x3;
    t  = t - x3;
    x3 = x0 + x2;
    x0 = x0 - x2;

    // sqrt(1/2) rotation
    x2 = (WR * (x4 + x5) + 128) >>> 8;
    x4 = (WR * (x4 - x5) + 128) >>> 8;

    r[0] = (x7 + x1) >>> 14;
    r[7] = (x7 - x1) >>> 14;
    r[1] = (x3 + x2) >>> 14;
    r[6] = (x3 - x2) >>> 14;
    r[2] = (x0 + x4) >>> 14;
    r[5] = (x0 - x4) >>> 14;
    r[3] = (t + x6) >>> 14;
    r[4] = (t - x6) >>> 14;
    for (int k = 0; k < 8; k++) begin
      pix[k] = 16'(r[k]);
    end
    return pix;
  endfunction

  function automatic col_t uniform_column(input logic [15:0] v);
    col_t c;
    for (int k = 0; k < 8; k++) begin
      c[k] = v;
    end
    return c;
  endfunction

  function automatic col_t impulse_column(input int lane, input logic [15:0] v);
    col_t c;
    c = '0;
    c[lane] = v;
    return c;
  endfunction

  // Mix of full-range noise, typical small coefficients, sparse columns and
  // columns built from the corner values.
  function automatic col_t random_column();
    col_t c;
    int unsigned kind;
    kind = $urandom_range(3);
    for (int k = 0; k < 8; k++) begin
      case (kind)
        0: begin
          c[k] = 16'($urandom);
        end
        1: begin
          c[k] = 16'(int'($urandom_range(4095)) - 2048);
        end
        2: begin
          c[k] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
        end
        default: begin
          case ($urandom_range(4))
            0: c[k] = 16'h7fff;
            1: c[k] = 16'h8000;
            2: c[k] = 16'h0000;
            3: c[k] = 16'hffff;
            default: c[k] = 16'($urandom);
          endcase
        end
      endcase
    end
    return c;
  endfunction

  // Driver: predicts on every accepted transaction, then presents the next
  // pending column unless it decides to idle this cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pix_expected.push_back(idct_column(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (coef_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= coef_pending.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction lane by lane against the
  // oldest prediction, and stalls the output at random.
  always @(posedge clk_i) begin
    col_t want;
    col_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pix_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected output transaction: %h", got);
        end
      end else begin
        want = pix_expected.pop_front();
        for (int k = 0; k < 8; k++) begin
          if (got[k] !== want[k]) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("pix_%0d mismatch: expected %0d, actual %0d", k,
                       $signed(want[k]), $signed(got[k]));
            end
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("idct_8point_column_pass_tb: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed columns: zeros, rails, alternating signs, lone DC and lone
    // AC terms at both extremes
    coef_pending.push_back(uniform_column(16'h0000));
    coef_pending.push_back(uniform_column(16'h0001));
    coef_pending.push_back(uniform_column(16'h7fff));
    coef_pending.push_back(uniform_column(16'h8000));
    coef_pending.push_back({4{16'h8000, 16'h7fff}});
    coef_pending.push_back({4{16'h7fff, 16'h8000}});
    for (int k = 0; k < 8; k++) begin
      coef_pending.push_back(impulse_column(k, 16'h7fff));
      coef_pending.push_back(impulse_column(k, 16'h8000));
    end

    // random columns, three traffic profiles
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 10;
          sink_stall_pct = 47;
        end
        1: begin
          src_idle_pct = 47;
          sink_stall_pct = 10;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_COLUMNS / 3; n++) begin
        coef_pending.push_back(random_column());
      end
      while (coef_pending.size() != 0) @(posedge clk_i);
    end

    while (s_axis_tvalid || pix_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pix_expected.size() == 0) begin
      $display("idct_8point_column_pass_tb: PASS");
    end else begin
      $display("idct_8point_column_pass_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/idct8_pkg.sv
rtl/core/idct8_ctl.sv
rtl/core/idct8_mul.sv
rtl/core/idct8_bfly.sv
rtl/core/idct8_fin.sv
rtl/core/idct_8point_column_pass.sv
verif/idct_8point_column_pass_tb.sv
